FILE: hdl/gchg_pkg.sv
// shared constants, codes and divider interface types for the change dispenser
`default_nettype none

package gchg_pkg;

    localparam int MAX_DENOMS      = 5;
    localparam int DENOM_W         = 8;
    localparam int AMT_W           = 16;
    localparam int PAID_W          = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int FUNC_W          = 2;
    localparam int STAT_W          = 2;

    localparam int NUM_DENOMS_DEF  = 5;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CHANGE = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_INSUF   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SHORT   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_UNKNOWN = 2'd3;

    typedef logic [DENOM_W-1:0] denom_t;

    localparam denom_t DENOM_RESET [MAX_DENOMS] = '{8'd1, 8'd2, 8'd10, 8'd20, 8'd40};

    localparam int DIV_STEPS = AMT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic             start;
        logic [AMT_W-1:0] dividend;
        denom_t           divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [AMT_W-1:0] quotient;
        denom_t           remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/gchg_div.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module gchg_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire gchg_pkg::div_req_t req,
    output gchg_pkg::div_rsp_t      rsp
);

    localparam int AW = gchg_pkg::AMT_W;
    localparam int DW = gchg_pkg::DENOM_W;
    localparam int CW = gchg_pkg::DIV_CNT_W;
    localparam logic [CW-1:0] LAST_STEP = CW'(gchg_pkg::DIV_STEPS - 1);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [AW-1:0]            quo_reg, quo_next;
    gchg_pkg::denom_t         rem_reg, rem_next;
    gchg_pkg::denom_t         dvs_reg, dvs_next;
    logic [DW:0]              trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[AW-1]};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = trial[DW-1:0] - dvs_reg;
                quo_next = {quo_reg[AW-2:0], 1'b1};
            end else begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[AW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

FILE: hdl/greedy_change_dispenser_top.sv
// bill stock keeper and greedy change sequencer, top level
//
//  channel  dir  handshake           word
//  s_       in   s_valid / s_ready   func, bill value, amount, change due
//  m_       out  m_valid / m_ready   paid counts, stock count, leftover, status
//  cfg_     in   cfg_wr_en           denomination index and value
//
//  query, add, remove: result registered once the output register is free
//  give change: select, 16 divider steps plus done, clamp and optional multiply-back
//  per enabled denomination, select alone per disabled one, then the finish state;
//  s_ready is high only between items, from the cycle the result appears; a
//  result waits in the output register until taken, holding the sequencer
`default_nettype none

module greedy_change_dispenser_top #(
    parameter int NUM_DENOMS  = gchg_pkg::NUM_DENOMS_DEF,
    parameter int COUNT_WIDTH = gchg_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [gchg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gchg_pkg::DENOM_W-1:0]    cfg_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [gchg_pkg::FUNC_W-1:0]     s_func,
    input  wire logic [gchg_pkg::DENOM_W-1:0]    s_bill_value,
    input  wire logic [gchg_pkg::AMT_W-1:0]      s_amount,
    input  wire logic [gchg_pkg::AMT_W-1:0]      s_change_due,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [gchg_pkg::PAID_W-1:0]          m_paid_0,
    output logic [gchg_pkg::PAID_W-1:0]          m_paid_1,
    output logic [gchg_pkg::PAID_W-1:0]          m_paid_2,
    output logic [gchg_pkg::PAID_W-1:0]          m_paid_3,
    output logic [gchg_pkg::PAID_W-1:0]          m_paid_4,
    output logic [gchg_pkg::PAID_W-1:0]          m_stock_count,
    output logic [gchg_pkg::AMT_W-1:0]           m_leftover,
    output logic [gchg_pkg::STAT_W-1:0]          m_status
);

    localparam int MD   = gchg_pkg::MAX_DENOMS;
    localparam int DW   = gchg_pkg::DENOM_W;
    localparam int AW   = gchg_pkg::AMT_W;
    localparam int PW   = gchg_pkg::PAID_W;
    localparam int FW   = gchg_pkg::FUNC_W;
    localparam int STW  = gchg_pkg::STAT_W;
    localparam int CIW  = gchg_pkg::CFG_IDX_W;
    localparam int IDX_W = $clog2(NUM_DENOMS);
    localparam int WW   = (COUNT_WIDTH > PW) ? COUNT_WIDTH : PW;
    localparam int SW   = WW + 1;
    localparam int MW   = AW + DW;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    localparam count_t           CNT_MAX     = '1;
    localparam logic [SW-1:0]    CNT_MAX_S   = SW'(CNT_MAX);
    localparam logic [WW-1:0]    PAID_MAX_W  = WW'({PW{1'b1}});
    localparam logic [CIW-1:0]   NUM_IDX     = CIW'(NUM_DENOMS);
    localparam logic [IDX_W-1:0] TOP_IDX     = IDX_W'(NUM_DENOMS - 1);
    localparam logic [AW-1:0]    ONE_HALF    = AW'(1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_CSEL   = 3'd2;
    localparam logic [2:0] S_CDIV   = 3'd3;
    localparam logic [2:0] S_CCLAMP = 3'd4;
    localparam logic [2:0] S_CMUL   = 3'd5;
    localparam logic [2:0] S_CFIN   = 3'd6;

    logic [2:0]         state_reg, state_next;
    gchg_pkg::denom_t   denom_reg [NUM_DENOMS];
    count_t             stock_reg [NUM_DENOMS];
    count_t             stock_next [NUM_DENOMS];
    logic [PW-1:0]      paid_reg [NUM_DENOMS];
    logic [PW-1:0]      paid_next [NUM_DENOMS];
    logic [PW-1:0]      paid_ext [MD];
    logic [FW-1:0]      func_reg;
    logic [DW-1:0]      bill_reg;
    logic [AW-1:0]      amt_reg;
    logic [AW-1:0]      rem_reg, rem_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [MW-1:0]      prod_reg, prod_next;

    logic               m_valid_reg;
    logic [PW-1:0]      m_paid_reg [MD];
    logic [PW-1:0]      m_paid_next [MD];
    logic [PW-1:0]      m_stock_count_reg, m_stock_count_next;
    logic [AW-1:0]      m_leftover_reg, m_leftover_next;
    logic [STW-1:0]     m_status_reg, m_status_next;
    logic               out_load;
    logic               out_free;

    logic [NUM_DENOMS-1:0] match;
    logic               found;
    logic               short_stock;
    count_t             q_stock;
    logic [WW-1:0]      q_wide;
    logic [PW-1:0]      q_count;
    logic [SW-1:0]      add_sum [NUM_DENOMS];
    gchg_pkg::denom_t   denom_cur;
    count_t             stock_cur;
    logic [WW-1:0]      stock_cur_w;
    logic [PW-1:0]      stock_cur_p;

    gchg_pkg::div_req_t div_req;
    gchg_pkg::div_rsp_t div_rsp;

    gchg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    assign denom_cur   = denom_reg[idx_reg];
    assign stock_cur   = stock_reg[idx_reg];
    assign stock_cur_w = WW'(stock_cur);
    assign stock_cur_p = stock_cur_w[PW-1:0];

    for (genvar g = 0; g < MD; g++) begin : g_paid
        if (g < NUM_DENOMS) begin : g_used
            assign paid_ext[g] = paid_reg[g];
        end else begin : g_unused
            assign paid_ext[g] = '0;
        end
    end

    // match, lookup and stock arithmetic on the captured word
    always_comb begin
        found       = 1'b0;
        short_stock = 1'b0;
        q_stock     = '0;
        for (int i = 0; i < NUM_DENOMS; i++) begin
            match[i]   = (denom_reg[i] != '0) && (denom_reg[i] == bill_reg);
            add_sum[i] = SW'(stock_reg[i]) + SW'(amt_reg);
            if (match[i]) begin
                found = 1'b1;
            end
            if (match[i] && (WW'(stock_reg[i]) < WW'(amt_reg))) begin
                short_stock = 1'b1;
            end
        end
        for (int i = NUM_DENOMS - 1; i >= 0; i--) begin
            if (match[i]) begin
                q_stock = stock_reg[i];
            end
        end
        q_wide  = WW'(q_stock);
        q_count = (q_wide > PAID_MAX_W) ? {PW{1'b1}} : q_wide[PW-1:0];
    end

    always_comb begin
        state_next         = state_reg;
        rem_next           = rem_reg;
        idx_next           = idx_reg;
        prod_next          = prod_reg;
        stock_next         = stock_reg;
        paid_next          = paid_reg;
        out_load           = 1'b0;
        m_paid_next        = m_paid_reg;
        m_stock_count_next = m_stock_count_reg;
        m_leftover_next    = m_leftover_reg;
        m_status_next      = m_status_reg;
        div_req.start      = 1'b0;
        div_req.dividend   = rem_reg;
        div_req.divisor    = denom_cur;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_func == gchg_pkg::FUNC_CHANGE) begin
                        state_next = S_CSEL;
                        idx_next   = TOP_IDX;
                        rem_next   = s_change_due;
                        for (int i = 0; i < NUM_DENOMS; i++) begin
                            paid_next[i] = '0;
                        end
                    end else begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    out_load           = 1'b1;
                    state_next         = S_IDLE;
                    m_stock_count_next = '0;
                    m_leftover_next    = '0;
                    m_status_next      = gchg_pkg::STAT_OK;
                    for (int i = 0; i < MD; i++) begin
                        m_paid_next[i] = '0;
                    end
                    if (!found) begin
                        m_status_next = gchg_pkg::STAT_UNKNOWN;
                    end else begin
                        case (func_reg)
                            gchg_pkg::FUNC_QUERY: begin
                                m_stock_count_next = q_count;
                            end
                            gchg_pkg::FUNC_ADD: begin
                                for (int i = 0; i < NUM_DENOMS; i++) begin
                                    if (match[i]) begin
                                        stock_next[i] = (add_sum[i] > CNT_MAX_S) ? CNT_MAX
                                                      : add_sum[i][COUNT_WIDTH-1:0];
                                    end
                                end
                            end
                            gchg_pkg::FUNC_REMOVE: begin
                                if (short_stock) begin
                                    m_status_next = gchg_pkg::STAT_SHORT;
                                end else begin
                                    for (int i = 0; i < NUM_DENOMS; i++) begin
                                        if (match[i]) begin
                                            stock_next[i] = count_t'(WW'(stock_reg[i])
                                                          - WW'(amt_reg));
                                        end
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_CSEL: begin
                if (denom_cur != '0) begin
                    div_req.start = 1'b1;
                    state_next    = S_CDIV;
                end else if (idx_reg == '0) begin
                    state_next = S_CFIN;
                end else begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            S_CDIV: begin
                if (div_rsp.done) begin
                    state_next = S_CCLAMP;
                end
            end
            S_CCLAMP: begin
                if (WW'(div_rsp.quotient) <= stock_cur_w) begin
                    paid_next[idx_reg] = div_rsp.quotient;
                    rem_next           = AW'(div_rsp.remainder);
                    if (idx_reg == '0) begin
                        state_next = S_CFIN;
                    end else begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = S_CSEL;
                    end
                end else begin
                    paid_next[idx_reg] = stock_cur_p;
                    prod_next          = stock_cur_p * denom_cur;
                    state_next         = S_CMUL;
                end
            end
            S_CMUL: begin
                rem_next = rem_reg - prod_reg[AW-1:0];
                if (idx_reg == '0) begin
                    state_next = S_CFIN;
                end else begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = S_CSEL;
                end
            end
            S_CFIN: begin
                if (out_free) begin
                    out_load           = 1'b1;
                    state_next         = S_IDLE;
                    m_stock_count_next = '0;
                    m_leftover_next    = rem_reg;
                    if (rem_reg > ONE_HALF) begin
                        m_status_next = gchg_pkg::STAT_INSUF;
                        for (int i = 0; i < MD; i++) begin
                            m_paid_next[i] = '0;
                        end
                    end else begin
                        m_status_next = gchg_pkg::STAT_OK;
                        for (int i = 0; i < MD; i++) begin
                            m_paid_next[i] = paid_ext[i];
                        end
                        for (int i = 0; i < NUM_DENOMS; i++) begin
                            stock_next[i] = stock_reg[i] - count_t'(paid_reg[i]);
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_DENOMS; i++) begin
                denom_reg[i] <= gchg_pkg::DENOM_RESET[i];
                stock_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            stock_reg <= stock_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en && (cfg_index < NUM_IDX)) begin
                denom_reg[cfg_index[IDX_W-1:0]] <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg <= s_func;
            bill_reg <= s_bill_value;
            amt_reg  <= s_amount;
        end
        rem_reg  <= rem_next;
        idx_reg  <= idx_next;
        prod_reg <= prod_next;
        paid_reg <= paid_next;
        if (out_load) begin
            m_paid_reg        <= m_paid_next;
            m_stock_count_reg <= m_stock_count_next;
            m_leftover_reg    <= m_leftover_next;
            m_status_reg      <= m_status_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_paid_0      = m_paid_reg[0];
    assign m_paid_1      = m_paid_reg[1];
    assign m_paid_2      = m_paid_reg[2];
    assign m_paid_3      = m_paid_reg[3];
    assign m_paid_4      = m_paid_reg[4];
    assign m_stock_count = m_stock_count_reg;
    assign m_leftover    = m_leftover_reg;
    assign m_status      = m_status_reg;

    a_one_word_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a word is in flight");

    a_stock_only_on_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_EXEC && state_reg != S_CFIN)
        |=> ($stable(stock_reg[0]) && $stable(stock_reg[NUM_DENOMS-1])))
        else $error("stock changed outside a commit");

    a_div_remainder: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CCLAMP) |-> (div_rsp.remainder < denom_cur))
        else $error("divider remainder not below divisor");

    a_payback_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMUL) |-> (prod_reg <= MW'(rem_reg)))
        else $error("stock payout exceeds remaining change");

endmodule

`default_nettype wire
